// ===== hdl/ps2rf_pkg.sv =====
// Package with the item codes, constants and widths of the PS/2 receive FIFO.
`timescale 1ns / 1ps
`default_nettype none

package ps2rf_pkg;

	// Item kinds on the input channel
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_EDGE = 2'd0;
	localparam kind_t KIND_READ = 2'd1;
	localparam kind_t KIND_TICK = 2'd2;

	// Frame and timing constants
	localparam int TIMEOUT_W = 16;
	localparam int COUNT_W   = 4;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd250;
	localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;
	localparam logic [COUNT_W-1:0]   FRAME_BITS    = 4'd11;
	localparam logic [COUNT_W-1:0]   LAST_DATA_BIT = 4'd7;

	typedef logic [7:0]           byte_t;
	typedef logic [TIMEOUT_W-1:0] ms_t;
	typedef logic [COUNT_W-1:0]   count_t;

endpackage

`default_nettype wire

// ===== hdl/ps2rf_if.sv =====
// Valid/ready channel interfaces for the input items and the read results.
`timescale 1ns / 1ps
`default_nettype none

interface ps2rf_item_if;
	import ps2rf_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	logic  data_bit;

	modport source (output valid, output kind, output data_bit, input ready);
	modport sink (input valid, input kind, input data_bit, output ready);
endinterface

interface ps2rf_result_if;
	import ps2rf_pkg::*;

	logic  valid;
	logic  ready;
	byte_t scan_code;
	logic  fifo_empty;

	modport source (output valid, output scan_code, output fifo_empty, input ready);
	modport sink (input valid, input scan_code, input fifo_empty, output ready);
endinterface

`default_nettype wire

// ===== hdl/ps2_receive_fifo.sv =====
// Top level of the PS/2 receiver with its byte FIFO.
`timescale 1ns / 1ps
`default_nettype none

// PS/2 frame receiver and byte FIFO. Every input item is one falling clock
// edge with its data bit, one millisecond tick, or one read request. Edges
// assemble 11-bit frames; data bits 1 to 8 form the byte, least significant
// bit first, and start, parity and stop bits are not checked. A completed
// byte is written to a ring FIFO of FIFO_DEPTH entries that keeps one slot
// free, so it holds FIFO_DEPTH-1 bytes; a byte that finds it full is lost.
// An edge that arrives after more than the programmed timeout of idle ticks
// discards any partial frame first. The block takes one item per clock
// cycle. A read gives its result in the cycle after its transfer, taken from the
// registered read port of the FIFO memory; the input is held off only while
// a result waits at the output and the output is not ready. Items of the
// unused kind are taken and ignored. The FIFO memory is not cleared.
module ps2_receive_fifo #(
	parameter int FIFO_DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire ps2rf_pkg::ms_t     cfg_wdata,
	ps2rf_item_if.sink              item,
	ps2rf_result_if.source          result
);
	import ps2rf_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	ms_t              timeout_q;
	count_t           bit_count_q;
	byte_t            shift_byte_q;
	ms_t              idle_ms_q;
	logic [PTR_W-1:0] write_ptr_q;
	logic [PTR_W-1:0] read_ptr_q;
	byte_t            fifo_mem [FIFO_DEPTH];

	logic             valid_s1;
	logic             empty_s1;
	byte_t            rdata_s1;

	logic             take;
	logic             timed_out;
	count_t           bc_base;
	byte_t            sb_base;
	byte_t            sb_next;
	count_t           bc_next;
	logic             frame_done;
	logic [PTR_W-1:0] wr_slot;
	logic [PTR_W-1:0] rd_slot;
	logic             fifo_full;
	logic             fifo_is_empty;

	// Input transfer and pointer arithmetic
	assign item.ready    = !valid_s1 || result.ready;
	assign take          = item.valid && item.ready;
	assign wr_slot       = (write_ptr_q == PTR_LAST) ? '0 : write_ptr_q + 1'b1;
	assign rd_slot       = (read_ptr_q == PTR_LAST) ? '0 : read_ptr_q + 1'b1;
	assign fifo_full     = (wr_slot == read_ptr_q);
	assign fifo_is_empty = (read_ptr_q == write_ptr_q);

	// Frame assembly for one edge: optional restart, shift in the bit, count.
	always_comb begin
		timed_out = (idle_ms_q > timeout_q);
		bc_base   = timed_out ? '0 : bit_count_q;
		sb_base   = timed_out ? '0 : shift_byte_q;
		sb_next   = sb_base;
		for (int i = 0; i <= int'(LAST_DATA_BIT); i++) begin
			if (bc_base == COUNT_W'(i + 1)) begin
				sb_next[i] = sb_base[i] | item.data_bit;
			end
		end
		bc_next    = bc_base + 1'b1;
		frame_done = (bc_next >= FRAME_BITS);
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Frame, idle and pointer state, updated at each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= '0;
			shift_byte_q <= '0;
			idle_ms_q    <= '0;
			write_ptr_q  <= '0;
			read_ptr_q   <= '0;
		end else if (take) begin
			case (item.kind)
				KIND_EDGE: begin
					idle_ms_q <= '0;
					if (frame_done) begin
						bit_count_q  <= '0;
						shift_byte_q <= '0;
						if (!fifo_full) begin
							write_ptr_q <= wr_slot;
						end
					end else begin
						bit_count_q  <= bc_next;
						shift_byte_q <= sb_next;
					end
				end
				KIND_TICK: begin
					if (idle_ms_q != IDLE_MAX) begin
						idle_ms_q <= idle_ms_q + 1'b1;
					end
				end
				KIND_READ: begin
					if (!fifo_is_empty) begin
						read_ptr_q <= rd_slot;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// FIFO memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (take && item.kind == KIND_EDGE && frame_done && !fifo_full) begin
			fifo_mem[wr_slot] <= sb_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.kind == KIND_READ) begin
			rdata_s1 <= fifo_mem[rd_slot];
			empty_s1 <= fifo_is_empty;
		end
	end

	// Result stage: holds a read result until it is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= take && (item.kind == KIND_READ);
		end
	end

	assign result.valid      = valid_s1;
	assign result.fifo_empty = empty_s1;
	assign result.scan_code  = empty_s1 ? '0 : rdata_s1;

endmodule

`default_nettype wire
